### rtl/tccw_pkg.sv
package tccw_pkg;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] FIXED_ATTR   = 8'h0F;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int IDX_W = 11;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_READ = 3'd0;
  localparam kind_t KIND_CR   = 3'd1;
  localparam kind_t KIND_NL   = 3'd2;
  localparam kind_t KIND_BS   = 3'd3;
  localparam kind_t KIND_TAB  = 3'd4;
  localparam kind_t KIND_CHAR = 3'd5;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         char_code;
    logic [IDX_W-1:0]   cell_index;
  } cmd_t;

endpackage

### rtl/text_console_char_writer.sv
// Text console engine with a COLUMNS x ROWS character store and a cursor. Opcode 0 puts a
// byte (carriage return, newline, backspace and tab move the cursor, anything else is
// stored and advances it); opcode 1 reads one cell. Every transfer in gives exactly one
// result with the cursor offset column + COLUMNS*row. After reset the store is blanked
// one cell a cycle, with in_ready low throughout. A two-entry command queue sits in front
// of the execution unit, so up to two items are taken while a result waits. Reads and
// ordinary puts are taken from the queue in the idle state and finished in a read or an
// execute state; the store has one write port and a registered read port. A put that
// starts below the last row first blanks the whole store before it executes.
module text_console_char_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_cursor_offset,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attribute,
  output logic        out_screen_cleared
);

  logic           cmd_valid;
  tccw_pkg::cmd_t cmd;
  logic           cmd_pop;
  logic           init_busy;

  tccw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .init_busy     (init_busy),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  tccw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_offset  (out_cursor_offset),
    .out_read_char      (out_read_char),
    .out_read_attribute (out_read_attribute),
    .out_screen_cleared (out_screen_cleared)
  );

endmodule

### rtl/tccw_ram.sv
module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tccw_front.sv
module tccw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [7:0]         in_char_code,
  input  logic [10:0]        in_cell_index,
  input  logic               init_busy,
  output logic               cmd_valid,
  output tccw_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);

  tccw_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  tccw_pkg::cmd_t in_cmd;
  logic           push;

  // classify the incoming byte
  always_comb begin
    in_cmd.char_code  = in_char_code;
    in_cmd.cell_index = in_cell_index;
    if (in_opcode == tccw_pkg::OP_READ) begin
      in_cmd.kind = tccw_pkg::KIND_READ;
    end else begin
      case (in_char_code)
        tccw_pkg::CH_RETURN:    in_cmd.kind = tccw_pkg::KIND_CR;
        tccw_pkg::CH_NEWLINE:   in_cmd.kind = tccw_pkg::KIND_NL;
        tccw_pkg::CH_BACKSPACE: in_cmd.kind = tccw_pkg::KIND_BS;
        tccw_pkg::CH_TAB:       in_cmd.kind = tccw_pkg::KIND_TAB;
        default:                in_cmd.kind = tccw_pkg::KIND_CHAR;
      endcase
    end
  end

  assign in_ready  = (cnt_r != 2'd2) && !init_busy;
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

### rtl/tccw_back.sv
module tccw_back #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  tccw_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        out_cursor_offset,
  output logic [7:0]         out_read_char,
  output logic [7:0]         out_read_attribute,
  output logic               out_screen_cleared
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + TAB_STOP);
  localparam int RW    = $clog2(ROWS + 2);
  localparam int PW    = $clog2(TAB_STOP);
  localparam int SW    = RW + 10;
  localparam int IW    = (AW > tccw_pkg::IDX_W) ? AW : tccw_pkg::IDX_W;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_EXEC = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [PW-1:0]  ph_r, ph_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  tccw_pkg::cmd_t cur_r, cur_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic           clr_r, clr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [10:0]    out_off_r, out_off_nxt;
  logic [7:0]     out_char_r, out_char_nxt;
  logic           out_clr_r, out_clr_nxt;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;
  logic [AW-1:0]  raddr;
  logic [7:0]     rdata;
  logic [IW-1:0]  idx_w;
  logic           idx_ok;
  logic [CW-1:0]  col_w;
  logic [RW-1:0]  row_w;
  logic [SW-1:0]  cur_sum;

  function automatic logic [SW-1:0] offset_of(logic [CW-1:0] c, logic [RW-1:0] r);
    return SW'(c) + SW'(r) * SW'(COLUMNS);
  endfunction

  assign idx_w   = IW'(cmd.cell_index);
  assign idx_ok  = idx_w < IW'(CELLS);
  assign raddr   = idx_w[AW-1:0];
  assign cur_sum = offset_of(col_r, row_r);

  assign init_busy          = (state_r == ST_INIT);
  assign out_valid          = out_valid_r;
  assign out_cursor_offset  = out_off_r;
  assign out_read_char      = out_char_r;
  assign out_read_attribute = tccw_pkg::FIXED_ATTR;
  assign out_screen_cleared = out_clr_r;

  tccw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    rd_ok_nxt     = rd_ok_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_off_nxt   = out_off_r;
    out_char_nxt  = out_char_r;
    out_clr_nxt   = out_clr_r;
    cmd_pop       = 1'b0;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = tccw_pkg::BLANK_CHAR;
    col_w         = col_r;
    row_w         = row_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT, ST_CLR: begin
        // blank sweep, one cell a cycle
        we      = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_EXEC;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && (!out_valid_r || out_ready)) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          if (cmd.kind == tccw_pkg::KIND_READ) begin
            rd_ok_nxt = idx_ok;
            state_nxt = ST_RD;
          end else begin
            // wrap a column past the edge, then clear if below the last row
            if (col_r >= CW'(COLUMNS)) begin
              col_w = '0;
              row_w = row_r + RW'(1);
            end
            col_nxt = col_w;
            if (col_r >= CW'(COLUMNS)) begin
              ph_nxt = '0;
            end
            if (row_w >= RW'(ROWS)) begin
              row_nxt   = '0;
              clr_nxt   = 1'b1;
              state_nxt = ST_CLR;
            end else begin
              row_nxt   = row_w;
              clr_nxt   = 1'b0;
              state_nxt = ST_EXEC;
            end
          end
        end
      end
      ST_EXEC: begin
        case (cur_r.kind)
          tccw_pkg::KIND_CR: begin
            col_w  = '0;
            ph_nxt = '0;
          end
          tccw_pkg::KIND_NL: begin
            col_w  = '0;
            row_w  = row_r + RW'(1);
            ph_nxt = '0;
          end
          tccw_pkg::KIND_BS: begin
            if (col_r != '0) begin
              col_w  = col_r - CW'(1);
              ph_nxt = (ph_r == '0) ? PW'(TAB_STOP - 1) : ph_r - PW'(1);
            end
          end
          tccw_pkg::KIND_TAB: begin
            col_w  = col_r + (CW'(TAB_STOP) - CW'(ph_r));
            ph_nxt = '0;
          end
          default: begin
            we     = 1'b1;
            waddr  = cur_sum[AW-1:0];
            wdata  = cur_r.char_code;
            col_w  = col_r + CW'(1);
            ph_nxt = (ph_r == PW'(TAB_STOP - 1)) ? '0 : ph_r + PW'(1);
          end
        endcase
        col_nxt       = col_w;
        row_nxt       = row_w;
        out_valid_nxt = 1'b1;
        out_off_nxt   = 11'(offset_of(col_w, row_w));
        out_char_nxt  = 8'h00;
        out_clr_nxt   = clr_r;
        state_nxt     = ST_IDLE;
      end
      ST_RD: begin
        out_valid_nxt = 1'b1;
        out_off_nxt   = cur_sum[10:0];
        out_char_nxt  = rd_ok_r ? rdata : 8'h00;
        out_clr_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      ph_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    rd_ok_r    <= rd_ok_nxt;
    clr_r      <= clr_nxt;
    out_off_r  <= out_off_nxt;
    out_char_r <= out_char_nxt;
    out_clr_r  <= out_clr_nxt;
  end

endmodule

### rtl/tccw_checker.sv
module tccw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_cursor_offset,
  input logic [7:0]  out_read_char,
  input logic [7:0]  out_read_attribute,
  input logic        out_screen_cleared
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_offset)
      && $stable(out_read_char) && $stable(out_screen_cleared))
    else $error("stalled result changed");

  a_attr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_read_attribute == 8'h0F)
    else $error("attribute not fixed");

  // a read never reports a clear, a put never reports a character
  a_rd_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_char != 8'h00 |-> !out_screen_cleared)
    else $error("read result flagged as cleared");

  // blanking pass follows reset
  a_init: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready && !out_valid)
    else $error("busy state missing after reset");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (.*);

### tb/console_result_checker.sv
module console_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] out_cursor_offset,
  input  logic [7:0]  out_read_char,
  input  logic [7:0]  out_read_attribute,
  input  logic        out_screen_cleared,
  output int          fail_count,
  output int          pending_count
);

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int SHOWN    = 10;

  typedef struct packed {
    logic [10:0] cur_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attribute;
    logic        screen_cleared;
  } console_result_t;

  int unsigned     cur_col;
  int unsigned     cur_row;
  logic [7:0]      screen [CELLS];
  console_result_t awaited_results [$];
  int              results_seen;

  function automatic console_result_t apply_console_op(input logic op, input logic [7:0] ch,
                                                       input logic [10:0] idx);
    console_result_t r;
    int unsigned slot;
    r.read_char      = 8'h00;
    r.read_attribute = tccw_pkg::FIXED_ATTR;
    r.screen_cleared = 1'b0;
    if (op == tccw_pkg::OP_READ) begin
      if (idx < CELLS) r.read_char = screen[idx];
    end else begin
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        cur_row = 0;
        for (int i = 0; i < CELLS; i++) screen[i] = tccw_pkg::BLANK_CHAR;
        r.screen_cleared = 1'b1;
      end
      case (ch)
        tccw_pkg::CH_RETURN: cur_col = 0;
        tccw_pkg::CH_NEWLINE: begin
          cur_col = 0;
          cur_row++;
        end
        tccw_pkg::CH_BACKSPACE: if (cur_col > 0) cur_col--;
        tccw_pkg::CH_TAB: cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
        default: begin
          slot = cur_col + COLUMNS * cur_row;
          if (slot < CELLS) screen[slot] = ch;
          cur_col++;
        end
      endcase
    end
    r.cur_pos = 11'(cur_col + COLUMNS * cur_row);
    return r;
  endfunction

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (!rst_n) begin
      cur_col = 0;
      cur_row = 0;
      foreach (screen[i]) screen[i] = tccw_pkg::BLANK_CHAR;
      awaited_results.delete();
      results_seen = 0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(apply_console_op(in_opcode, in_char_code, in_cell_index));
      if (out_valid && out_ready) begin
        got = {out_cursor_offset, out_read_char, out_read_attribute, out_screen_cleared};
        if (awaited_results.size() == 0) begin
          if (fail_count < SHOWN)
            $display("result %0d with nothing awaited: offset %0d char %02h attr %02h cleared %0b",
                     results_seen, got.cur_pos, got.read_char, got.read_attribute,
                     got.screen_cleared);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (fail_count < SHOWN) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected offset %0d char %02h attr %02h cleared %0b",
                       want.cur_pos, want.read_char, want.read_attribute,
                       want.screen_cleared);
              $display("  actual   offset %0d char %02h attr %02h cleared %0b",
                       got.cur_pos, got.read_char, got.read_attribute,
                       got.screen_cleared);
            end
            fail_count++;
          end
        end
        results_seen++;
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

### tb/tb_text_console_char_writer.sv
module tb_text_console_char_writer;

  localparam int ITEM_TARGET = 1250;
  localparam int IDLE_LIMIT  = 12000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 50;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] out_cursor_offset;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attribute;
  logic        out_screen_cleared;

  int fail_count;
  int pending_count;
  int items_sent;
  int burst_left;
  int results_taken;
  int idle_cycles;

  text_console_char_writer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_offset  (out_cursor_offset),
    .out_read_char      (out_read_char),
    .out_read_attribute (out_read_attribute),
    .out_screen_cleared (out_screen_cleared)
  );

  console_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_offset  (out_cursor_offset),
    .out_read_char      (out_read_char),
    .out_read_attribute (out_read_attribute),
    .out_screen_cleared (out_screen_cleared),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one transfer on the input side, with bursts and gaps between them
  task automatic offer(input logic op, input logic [7:0] ch, input logic [10:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] ch);
    offer(tccw_pkg::OP_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [10:0] idx);
    offer(tccw_pkg::OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  function automatic logic [7:0] glyph();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == tccw_pkg::CH_RETURN || ch == tccw_pkg::CH_NEWLINE ||
        ch == tccw_pkg::CH_BACKSPACE || ch == tccw_pkg::CH_TAB)
      ch = ch ^ 8'h40;
    return ch;
  endfunction

  function automatic logic [10:0] random_cell();
    return ($urandom_range(0, 9) == 0) ? 11'($urandom_range(2000, 2047))
                                       : 11'($urandom_range(0, 1999));
  endfunction

  task automatic mixed_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) read_cell(random_cell());
    else if (pick < 60) put_byte(8'($urandom_range(0, 255)));
    else if (pick < 68) put_byte(tccw_pkg::CH_RETURN);
    else if (pick < 80) put_byte(tccw_pkg::CH_NEWLINE);
    else if (pick < 90) put_byte(tccw_pkg::CH_BACKSPACE);
    else put_byte(tccw_pkg::CH_TAB);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) results_taken++;
  end

  // receiver: changing stall patterns, and one long hold-off to back the block up
  initial begin
    int mode;
    int span;
    int phase;
    bit held;
    held = 1'b0;
    phase = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && results_taken >= 60) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        phase++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((phase % 12) < 7);
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= tccw_pkg::OP_PUT;
    in_char_code  <= 8'h00;
    in_cell_index <= 11'd0;
    items_sent    = 0;
    burst_left    = 0;
    results_taken = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: read extremes, byte extremes, backspace floor, tab past the edge,
    // read with a pending cursor, wrap on the next put
    read_cell(11'd0);
    read_cell(11'd1999);
    read_cell(11'd2000);
    read_cell(11'd2047);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h41);
    repeat (4) put_byte(tccw_pkg::CH_BACKSPACE);
    put_byte(tccw_pkg::CH_RETURN);
    repeat (10) put_byte(tccw_pkg::CH_TAB);
    read_cell(11'd0);
    put_byte(8'h5A);
    put_byte(tccw_pkg::CH_NEWLINE);
    read_cell(11'd80);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(40, 100);
          repeat (len) begin
            case ($urandom_range(0, 19))
              0, 1: put_byte(tccw_pkg::CH_TAB);
              2: put_byte(tccw_pkg::CH_BACKSPACE);
              3: read_cell(random_cell());
              default: put_byte(glyph());
            endcase
          end
          if ($urandom_range(0, 1)) put_byte(tccw_pkg::CH_NEWLINE);
        end
        3, 4: begin
          len = $urandom_range(1, 30);
          repeat (len) begin
            if ($urandom_range(0, 5) == 0) read_cell(random_cell());
            else put_byte(tccw_pkg::CH_NEWLINE);
          end
        end
        5, 6, 7: begin
          len = $urandom_range(5, 30);
          repeat (len) mixed_item();
        end
        8: begin
          len = $urandom_range(3, 12);
          repeat (len) read_cell(11'($urandom_range(0, 2047)));
        end
        default: begin
          put_byte(tccw_pkg::CH_RETURN);
          len = $urandom_range(9, 11);
          repeat (len) put_byte(tccw_pkg::CH_TAB);
          read_cell(random_cell());
          if ($urandom_range(0, 1)) put_byte(glyph());
          else put_byte(tccw_pkg::CH_NEWLINE);
        end
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_front.sv
rtl/tccw_back.sv
rtl/text_console_char_writer.sv
rtl/tccw_checker.sv
tb/console_result_checker.sv
tb/tb_text_console_char_writer.sv
